// ----- rtl/spi_slave_command_responder_unit_assert.svh -----
// assertion macros for the spi slave command responder
// expects signals named clock and reset in the module that uses them
`ifndef SPI_SLAVE_COMMAND_RESPONDER_UNIT_ASSERT_SVH
`define SPI_SLAVE_COMMAND_RESPONDER_UNIT_ASSERT_SVH

// checked on every clock edge outside reset
`define SCR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every clock edge, reset included
`define SCR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/spi_scr_pkg.sv -----
// shared types, codes and constants for the spi slave command responder
// no dependencies
`timescale 1ns / 1ps

package spi_scr_pkg;

   // default store depth
   localparam int STORE_DEPTH_DEFAULT = 32;

   // register reset values
   localparam logic [7:0] START_BYTE_RESET = 8'h7B;
   localparam logic [7:0] END_BYTE_RESET   = 8'h7D;
   localparam logic [7:0] IDLE_BYTE_RESET  = 8'h58;

   // register indexes
   localparam logic [1:0] CSR_START_BYTE = 2'd0;
   localparam logic [1:0] CSR_END_BYTE   = 2'd1;
   localparam logic [1:0] CSR_IDLE_BYTE  = 2'd2;

   // request functions
   typedef enum logic [1:0] {
      FUNC_EXCHANGE = 2'd0,
      FUNC_LOAD     = 2'd1,
      FUNC_READY    = 2'd2,
      FUNC_READ     = 2'd3
   } func_type;

   // framer phases
   typedef enum logic [1:0] {
      PH_LISTEN  = 2'd0,
      PH_CAPTURE = 2'd1,
      PH_WAIT    = 2'd2,
      PH_SEND    = 2'd3
   } phase_type;

   // configuration registers
   typedef struct packed {
      logic [7:0] start_byte;
      logic [7:0] end_byte;
      logic [7:0] idle_byte;
   } cfg_type;

   // request payload
   typedef struct packed {
      logic [1:0] func;
      logic [7:0] rx_byte;
      logic [4:0] slot;
      logic [7:0] load_byte;
   } req_type;

   // response payload
   typedef struct packed {
      logic [7:0] tx_byte;
      logic [1:0] fsm_state;
      logic       request_pending;
      logic [5:0] command_length;
      logic [7:0] read_byte;
      logic       overflow;
   } rsp_type;

endpackage

// ----- rtl/spi_scr_ram.sv -----
// simple dual port store: one write port, one registered read port
// write-first on a same-address collision; no dependencies
`timescale 1ns / 1ps

module spi_scr_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 8,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read with write bypass
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= (we && (waddr == raddr)) ? wdata : mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/spi_scr_fsm.sv -----
// framer state machine: phase, capture and send positions, request flags
// uses spi_scr_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "spi_slave_command_responder_unit_assert.svh"

module spi_scr_fsm #(
   parameter int STORE_DEPTH = spi_scr_pkg::STORE_DEPTH_DEFAULT,
   localparam int AW = $clog2(STORE_DEPTH),
   localparam int CW = $clog2(STORE_DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  spi_scr_pkg::req_type req,
   input  spi_scr_pkg::cfg_type cfg,
   input  logic [7:0]           reply_rdata,
   output spi_scr_pkg::rsp_type rsp,
   output logic                 cmd_we,
   output logic [AW-1:0]        cmd_waddr,
   output logic [AW-1:0]        reply_raddr
);

   spi_scr_pkg::phase_type phase_ff, phase_in;
   logic [CW-1:0] capture_pos_ff, capture_pos_in;
   logic [AW-1:0] send_pos_ff, send_pos_in;
   logic          request_ff, request_in;
   logic          ready_ff, ready_in;
   logic          overflow_ff, overflow_in;
   logic          sending;
   logic [CW+5:0] cap_ext;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= spi_scr_pkg::PH_LISTEN;
         capture_pos_ff <= '0;
         send_pos_ff    <= '0;
         request_ff     <= 1'b0;
         ready_ff       <= 1'b0;
         overflow_ff    <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         capture_pos_ff <= capture_pos_in;
         send_pos_ff    <= send_pos_in;
         request_ff     <= request_in;
         ready_ff       <= ready_in;
         overflow_ff    <= overflow_in;
      end
   end

   // next state: one byte may fall through listen, capture and wait in order, or through wait, send and back to listen
   always_comb begin
      spi_scr_pkg::phase_type ph;
      logic [CW-1:0] cap;
      logic [AW-1:0] spos;
      logic          rq;
      logic          rdy;
      logic          ovf;
      ph        = phase_ff;
      cap       = capture_pos_ff;
      spos      = send_pos_ff;
      rq        = request_ff;
      rdy       = ready_ff;
      ovf       = overflow_ff;
      sending   = 1'b0;
      cmd_we    = 1'b0;
      cmd_waddr = capture_pos_ff[AW-1:0];
      if (accept) begin
         unique case (spi_scr_pkg::func_type'(req.func))
            spi_scr_pkg::FUNC_EXCHANGE: begin
               if ((ph == spi_scr_pkg::PH_LISTEN) && (req.rx_byte == cfg.start_byte)) begin
                  ph  = spi_scr_pkg::PH_CAPTURE;
                  cap = '0;
                  ovf = 1'b0;
               end
               if (ph == spi_scr_pkg::PH_CAPTURE) begin
                  if (cap < CW'(STORE_DEPTH)) begin
                     cmd_we    = 1'b1;
                     cmd_waddr = cap[AW-1:0];
                     cap       = cap + 1'b1;
                  end else begin
                     ovf = 1'b1;
                  end
                  if (req.rx_byte == cfg.end_byte) begin
                     ph = spi_scr_pkg::PH_WAIT;
                     rq = 1'b1;
                  end
               end
               if ((ph == spi_scr_pkg::PH_WAIT) && rdy) begin
                  ph   = spi_scr_pkg::PH_SEND;
                  rdy  = 1'b0;
                  rq   = 1'b0;
                  spos = '0;
               end
               if (ph == spi_scr_pkg::PH_SEND) begin
                  sending = 1'b1;
                  if (reply_rdata == cfg.end_byte) begin
                     ph = spi_scr_pkg::PH_LISTEN;
                  end else if (spos == AW'(STORE_DEPTH - 1)) begin
                     spos = '0;
                  end else begin
                     spos = spos + 1'b1;
                  end
               end
            end
            spi_scr_pkg::FUNC_READY: begin
               if (request_ff) begin
                  rdy = 1'b1;
               end
            end
            spi_scr_pkg::FUNC_LOAD, spi_scr_pkg::FUNC_READ: begin
            end
         endcase
      end
      // outside send the pointer rests at zero so entry zero is prefetched
      if (ph != spi_scr_pkg::PH_SEND) begin
         spos = '0;
      end
      phase_in       = ph;
      capture_pos_in = cap;
      send_pos_in    = spos;
      request_in     = rq;
      ready_in       = rdy;
      overflow_in    = ovf;
   end

   // prefetch the reply byte for the next exchange
   assign reply_raddr = send_pos_in;

   assign cap_ext = {6'b0, capture_pos_in};

   // response fields after the step; read_byte is filled in by the top level
   always_comb begin
      rsp = '0;
      if (sending) begin
         rsp.tx_byte = reply_rdata;
      end else if (spi_scr_pkg::func_type'(req.func) == spi_scr_pkg::FUNC_EXCHANGE) begin
         rsp.tx_byte = cfg.idle_byte;
      end
      rsp.fsm_state       = phase_in;
      rsp.request_pending = request_in;
      rsp.command_length  = cap_ext[5:0];
      rsp.read_byte       = '0;
      rsp.overflow        = overflow_in;
   end

   // consistency checks
   `SCR_ASSERT(a_request_in_wait, request_ff |-> (phase_ff == spi_scr_pkg::PH_WAIT), "request outside wait")
   `SCR_ASSERT(a_ready_needs_request, ready_ff |-> request_ff, "reply ready without request")
   `SCR_ASSERT(a_overflow_full, overflow_ff |-> (capture_pos_ff == CW'(STORE_DEPTH)), "overflow below full")
   `SCR_ASSERT(a_send_pos_rest, (phase_ff != spi_scr_pkg::PH_SEND) |-> (send_pos_ff == '0), "send pointer not at rest")

endmodule

// ----- rtl/spi_slave_command_responder_unit.sv -----
// top level of the spi slave command responder: handshake, registers, stores
// uses spi_scr_pkg, spi_scr_ram and spi_scr_fsm
`timescale 1ns / 1ps
// latency: a request's response is valid the cycle after it is taken
// throughput: one request per cycle; req_ready drops only while a response is held
// reply bytes are prefetched from the reply store's registered read port ahead of each exchange
// reset: synchronous, clears phase, positions, flags and registers to defaults
// the command and reply stores are not cleared and hold garbage until written

module spi_slave_command_responder_unit #(
   parameter int STORE_DEPTH = spi_scr_pkg::STORE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  spi_scr_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output spi_scr_pkg::rsp_type rsp_data,
   input  logic                 csr_we,
   input  logic [1:0]           csr_addr,
   input  logic [7:0]           csr_wdata
);

   localparam int AW = $clog2(STORE_DEPTH);

   spi_scr_pkg::cfg_type cfg_ff;
   spi_scr_pkg::rsp_type rsp_ff, step_rsp;
   logic                 rsp_valid_ff;
   logic                 read_sel_ff;
   logic                 accept;
   logic                 slot_ok;
   logic [AW+4:0]        slot_ext;
   logic [AW-1:0]        slot_addr;
   logic                 is_load;
   logic                 is_read;
   logic                 cmd_we;
   logic [AW-1:0]        cmd_waddr;
   logic [7:0]           cmd_rdata;
   logic [AW-1:0]        reply_raddr;
   logic [7:0]           reply_rdata;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte <= spi_scr_pkg::START_BYTE_RESET;
         cfg_ff.end_byte   <= spi_scr_pkg::END_BYTE_RESET;
         cfg_ff.idle_byte  <= spi_scr_pkg::IDLE_BYTE_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            spi_scr_pkg::CSR_START_BYTE: cfg_ff.start_byte <= csr_wdata;
            spi_scr_pkg::CSR_END_BYTE:   cfg_ff.end_byte   <= csr_wdata;
            spi_scr_pkg::CSR_IDLE_BYTE:  cfg_ff.idle_byte  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // handshake
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // slot decode
   assign slot_ext  = {{AW{1'b0}}, req_data.slot};
   assign slot_addr = slot_ext[AW-1:0];
   assign slot_ok   = ({27'b0, req_data.slot} < 32'(STORE_DEPTH));
   assign is_load   = (spi_scr_pkg::func_type'(req_data.func) == spi_scr_pkg::FUNC_LOAD);
   assign is_read   = (spi_scr_pkg::func_type'(req_data.func) == spi_scr_pkg::FUNC_READ);

   // framer
   spi_scr_fsm #(
      .STORE_DEPTH(STORE_DEPTH)
   ) u_fsm (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_data),
      .cfg         (cfg_ff),
      .reply_rdata (reply_rdata),
      .rsp         (step_rsp),
      .cmd_we      (cmd_we),
      .cmd_waddr   (cmd_waddr),
      .reply_raddr (reply_raddr)
   );

   // command store: written on capture, read at slot on a read request
   spi_scr_ram #(
      .DEPTH(STORE_DEPTH),
      .WIDTH(8)
   ) u_cmd_store (
      .clock (clock),
      .we    (cmd_we),
      .waddr (cmd_waddr),
      .wdata (req_data.rx_byte),
      .re    (accept && is_read),
      .raddr (slot_addr),
      .rdata (cmd_rdata)
   );

   // reply store: written on load, read continuously at the send pointer
   spi_scr_ram #(
      .DEPTH(STORE_DEPTH),
      .WIDTH(8)
   ) u_reply_store (
      .clock (clock),
      .we    (accept && is_load && slot_ok),
      .waddr (slot_addr),
      .wdata (req_data.load_byte),
      .re    (1'b1),
      .raddr (reply_raddr),
      .rdata (reply_rdata)
   );

   // response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff      <= step_rsp;
         read_sel_ff <= is_read && slot_ok;
      end
   end

   // response assembly
   always_comb begin
      rsp_data           = rsp_ff;
      rsp_data.read_byte = read_sel_ff ? cmd_rdata : 8'h00;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
